// ===== design/evmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmp_pkg
// Shared types and constants of the Euler angle view matrix packet block.
// ----------------------------------------------------------------------------
package evmp_pkg;

    localparam int unsigned PacketWords = 52;
    localparam int unsigned MaxSteps    = 24;
    localparam logic signed [31:0] FixOne = 32'sd65536;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    // Pose after the front part: the nine matrix entries and the position.
    typedef struct packed {
        logic signed [33:0] m0;
        logic signed [33:0] m1;
        logic signed [33:0] m2;
        logic signed [33:0] m4;
        logic signed [33:0] m5;
        logic signed [33:0] m6;
        logic signed [33:0] m8;
        logic signed [33:0] m9;
        logic signed [33:0] m10;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } t_pose;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MATRIX
    } t_front_state;

    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/evmp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmp_front
// Accepts a pose, runs three CORDIC lanes and forms the rotation matrix.
// ----------------------------------------------------------------------------
module evmp_front #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic signed [15:0]  i_angle_x,
    input  logic signed [15:0]  i_angle_y,
    input  logic signed [15:0]  i_angle_z,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    output logic                o_valid,
    input  logic                i_ready,
    output evmp_pkg::t_pose     o_pose
);

    localparam int Steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    evmp_pkg::t_front_state r_state, n_state;
    logic [4:0]  r_step;
    logic [3:0]  r_mstep;
    logic        r_valid;
    logic signed [33:0] r_x [3];
    logic signed [33:0] r_y [3];
    logic signed [33:0] r_z [3];
    logic [2:0]  r_flip;
    logic signed [31:0] r_px, r_py, r_pz;
    // Matrix sequencer: one shared multiplier, products held in r_p.
    logic signed [33:0] r_p [16];
    evmp_pkg::t_pose r_pose;

    logic signed [33:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    logic signed [33:0] w_q;
    logic [2:0]         w_flip;
    logic signed [33:0] w_z0 [3];

    assign w_sx = r_flip[0] ? -r_y[0] : r_y[0];
    assign w_cx = r_flip[0] ? -r_x[0] : r_x[0];
    assign w_sy = r_flip[1] ? -r_y[1] : r_y[1];
    assign w_cy = r_flip[1] ? -r_x[1] : r_x[1];
    assign w_sz = r_flip[2] ? -r_y[2] : r_y[2];
    assign w_cz = r_flip[2] ? -r_x[2] : r_x[2];

    // Angle fold into [-quarter, quarter].
    always_comb begin
        logic signed [16:0] a [3];
        a[0] = 17'(i_angle_x);
        a[1] = 17'(i_angle_y);
        a[2] = 17'(i_angle_z);
        for (int k = 0; k < 3; k++) begin
            w_flip[k] = 1'b0;
            if (a[k] > 17'sd16384) begin
                a[k] = a[k] - 17'sd32768;
                w_flip[k] = 1'b1;
            end else if (a[k] < -17'sd16384) begin
                a[k] = a[k] + 17'sd32768;
                w_flip[k] = 1'b1;
            end
            w_z0[k] = {a[k][16], a[k], 16'd0};
        end
    end

    // Multiplier operand selection by sequencer step.
    always_comb begin
        case (r_mstep)
            4'd0:  begin w_ma = w_cy;    w_mb = w_cz; end   // cc
            4'd1:  begin w_ma = w_cy;    w_mb = w_sz; end   // cs
            4'd2:  begin w_ma = w_sy;    w_mb = w_cz; end   // sc
            4'd3:  begin w_ma = w_sy;    w_mb = w_sz; end   // ss
            4'd4:  begin w_ma = r_p[3];  w_mb = w_sx; end   // ss*sx
            4'd5:  begin w_ma = w_cx;    w_mb = w_sz; end   // m1
            4'd6:  begin w_ma = r_p[1];  w_mb = w_sx; end   // cs*sx
            4'd7:  begin w_ma = r_p[2];  w_mb = w_sx; end   // sc*sx
            4'd8:  begin w_ma = w_cx;    w_mb = w_cz; end   // m5
            4'd9:  begin w_ma = r_p[0];  w_mb = w_sx; end   // cc*sx
            4'd10: begin w_ma = w_cx;    w_mb = w_sy; end   // m8
            4'd11: begin w_ma = w_cy;    w_mb = w_cx; end   // m10
            default: begin w_ma = '0;    w_mb = '0;   end
        endcase
        w_prod = w_ma * w_mb;
        w_q    = 34'(w_prod >>> 30);
    end

    assign o_full  = (r_state != evmp_pkg::ST_IDLE) || r_valid;
    assign o_valid = r_valid;
    assign o_pose  = r_pose;

    always_comb begin
        n_state = r_state;
        case (r_state)
            evmp_pkg::ST_IDLE:   if (i_push && !r_valid) n_state = evmp_pkg::ST_CORDIC;
            evmp_pkg::ST_CORDIC: if (r_step == 5'(Steps - 1)) n_state = evmp_pkg::ST_MATRIX;
            evmp_pkg::ST_MATRIX: if (r_mstep == 4'd11) n_state = evmp_pkg::ST_IDLE;
            default:             n_state = evmp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= evmp_pkg::ST_IDLE;
            r_valid <= 1'b0;
            r_step  <= '0;
            r_mstep <= '0;
        end else begin
            r_state <= n_state;
            if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                evmp_pkg::ST_IDLE: begin
                    r_step  <= '0;
                    r_mstep <= '0;
                end
                evmp_pkg::ST_CORDIC: r_step <= r_step + 5'd1;
                evmp_pkg::ST_MATRIX: begin
                    r_mstep <= r_mstep + 4'd1;
                    if (r_mstep == 4'd11) r_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            evmp_pkg::ST_IDLE: begin
                if (i_push && !r_valid) begin
                    for (int k = 0; k < 3; k++) begin
                        r_x[k] <= evmp_pkg::CordicGain;
                        r_y[k] <= '0;
                        r_z[k] <= w_z0[k];
                    end
                    r_flip <= w_flip;
                    r_px <= i_pos_x;
                    r_py <= i_pos_y;
                    r_pz <= i_pos_z;
                end
            end
            evmp_pkg::ST_CORDIC: begin
                for (int k = 0; k < 3; k++) begin
                    if (!r_z[k][33]) begin
                        r_x[k] <= r_x[k] - (r_y[k] >>> r_step);
                        r_y[k] <= r_y[k] + (r_x[k] >>> r_step);
                        r_z[k] <= r_z[k] - evmp_pkg::atan_turn(r_step);
                    end else begin
                        r_x[k] <= r_x[k] + (r_y[k] >>> r_step);
                        r_y[k] <= r_y[k] - (r_x[k] >>> r_step);
                        r_z[k] <= r_z[k] + evmp_pkg::atan_turn(r_step);
                    end
                end
            end
            evmp_pkg::ST_MATRIX: begin
                r_p[r_mstep] <= w_q;
                if (r_mstep == 4'd11) begin
                    r_pose.m0  <= r_p[0] + r_p[4];
                    r_pose.m1  <= r_p[5];
                    r_pose.m2  <= r_p[6] - r_p[2];
                    r_pose.m4  <= r_p[7] - r_p[1];
                    r_pose.m5  <= r_p[8];
                    r_pose.m6  <= r_p[9] + r_p[3];
                    r_pose.m8  <= r_p[10];
                    r_pose.m9  <= -w_sx;
                    r_pose.m10 <= w_q;
                    r_pose.px  <= r_px;
                    r_pose.py  <= r_py;
                    r_pose.pz  <= r_pz;
                end
            end
            default: ;
        endcase
    end

    // Pose is handed on only after the sequencer finishes.
    a_valid_after_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(r_state) == evmp_pkg::ST_MATRIX)
        else $error("pose valid without matrix pass");
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == evmp_pkg::ST_CORDIC) |-> o_full)
        else $error("front not full while busy");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == evmp_pkg::ST_CORDIC) |-> (r_step < 5'(Steps)))
        else $error("CORDIC step out of range");

endmodule

// ===== design/evmp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evmp_back
// Takes a pose and streams the 52 packet words, working out translations.
// ----------------------------------------------------------------------------
module evmp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  evmp_pkg::t_pose     i_pose,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [5:0]          o_word_index,
    output logic signed [31:0]  o_word_value,
    output logic                o_last_word
);

    evmp_pkg::t_pose r_pose;
    logic        r_busy;
    logic [5:0]  r_idx;
    // Translation pass: nine products, one per cycle, before streaming.
    logic [3:0]  r_tstep;
    logic        r_tdone;
    logic signed [49:0] r_acc;
    logic signed [31:0] r_t [3];

    logic signed [33:0] w_e;
    logic signed [31:0] w_p;
    logic signed [65:0] w_prod;
    logic signed [49:0] w_sum;
    logic signed [49:0] w_neg;
    logic signed [31:0] w_sat;
    logic signed [31:0] w_val;

    function automatic logic signed [31:0] q16(input logic signed [33:0] v);
        logic signed [33:0] s;
        s = v >>> 14;
        return s[31:0];
    endfunction

    always_comb begin
        case (r_tstep)
            4'd0: begin w_e = r_pose.m0;  w_p = r_pose.px; end
            4'd1: begin w_e = r_pose.m1;  w_p = r_pose.py; end
            4'd2: begin w_e = r_pose.m2;  w_p = r_pose.pz; end
            4'd3: begin w_e = r_pose.m4;  w_p = r_pose.px; end
            4'd4: begin w_e = r_pose.m5;  w_p = r_pose.py; end
            4'd5: begin w_e = r_pose.m6;  w_p = r_pose.pz; end
            4'd6: begin w_e = r_pose.m8;  w_p = r_pose.px; end
            4'd7: begin w_e = r_pose.m9;  w_p = r_pose.py; end
            4'd8: begin w_e = r_pose.m10; w_p = r_pose.pz; end
            default: begin w_e = '0; w_p = '0; end
        endcase
        w_prod = w_e * w_p;
        w_sum  = r_acc + 50'(w_prod >>> 14);
        w_neg  = -w_sum;
        w_neg  = w_neg >>> 16;
        if (w_neg > 50'sd2147483647)       w_sat = 32'sh7fffffff;
        else if (w_neg < -50'sd2147483648) w_sat = 32'sh80000000;
        else                               w_sat = w_neg[31:0];
    end

    always_comb begin
        case (r_idx)
            6'd0, 6'd16, 6'd40: w_val = q16(r_pose.m0);
            6'd1, 6'd20, 6'd41: w_val = q16(r_pose.m1);
            6'd2, 6'd24, 6'd42: w_val = q16(r_pose.m2);
            6'd4, 6'd17, 6'd32: w_val = q16(r_pose.m4);
            6'd5, 6'd21, 6'd33: w_val = q16(r_pose.m5);
            6'd6, 6'd25, 6'd34: w_val = q16(r_pose.m6);
            6'd8, 6'd18, 6'd36: w_val = q16(r_pose.m8);
            6'd9, 6'd22, 6'd37: w_val = q16(r_pose.m9);
            6'd10, 6'd26, 6'd38: w_val = q16(r_pose.m10);
            6'd12, 6'd48: w_val = r_pose.px;
            6'd13, 6'd49: w_val = r_pose.py;
            6'd14, 6'd50: w_val = r_pose.pz;
            6'd28: w_val = r_t[0];
            6'd29: w_val = r_t[1];
            6'd30: w_val = r_t[2];
            6'd15, 6'd31, 6'd35, 6'd39, 6'd43, 6'd51: w_val = evmp_pkg::FixOne;
            default: w_val = '0;
        endcase
    end

    assign o_ready      = !r_busy;
    assign o_empty      = !(r_busy && r_tdone);
    assign o_word_index = r_idx;
    assign o_word_value = w_val;
    assign o_last_word  = (r_idx == 6'(evmp_pkg::PacketWords - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_tdone <= 1'b0;
            r_idx   <= '0;
            r_tstep <= '0;
        end else if (!r_busy) begin
            if (i_valid) begin
                r_busy  <= 1'b1;
                r_tdone <= 1'b0;
                r_idx   <= '0;
                r_tstep <= '0;
            end
        end else if (!r_tdone) begin
            r_tstep <= r_tstep + 4'd1;
            if (r_tstep == 4'd8) r_tdone <= 1'b1;
        end else if (i_pop) begin
            if (o_last_word) r_busy <= 1'b0;
            r_idx <= r_idx + 6'd1;
        end
    end

    // Each row's third product closes its translation word.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_valid) begin
            r_pose <= i_pose;
            r_acc  <= '0;
        end else if (r_busy && !r_tdone) begin
            case (r_tstep)
                4'd2: begin
                    r_t[0] <= w_sat;
                    r_acc  <= '0;
                end
                4'd5: begin
                    r_t[1] <= w_sat;
                    r_acc  <= '0;
                end
                4'd8: begin
                    r_t[2] <= w_sat;
                    r_acc  <= '0;
                end
                default: r_acc <= w_sum;
            endcase
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx < 6'(evmp_pkg::PacketWords))
        else $error("word index out of range");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_last_word) |=> !r_busy)
        else $error("packet did not end after last word");
    a_no_words_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tdone |-> o_empty)
        else $error("word shown before translation pass");

endmodule

// ===== design/euler_view_matrix_packet.sv =====
`timescale 1ns / 1ps
// Flow: a pose passes through the CORDIC steps (CORDIC_STEPS, at most 24), the
// matrix sequencer, a hand-over into the back and its translation pass before
// word 0 is shown. The back then transfers the 52 words; with a receiver that
// never stalls, the front works on the next pose meanwhile, so the back sets
// the rate.
// Reset: synchronous, active low; both parts return to idle, no words held.
// ----------------------------------------------------------------------------
// euler_view_matrix_packet
// Turns three Euler angles and a camera position into a 52-word packet.
// ----------------------------------------------------------------------------
module euler_view_matrix_packet #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [15:0]  i_angle_x,
    input  logic signed [15:0]  i_angle_y,
    input  logic signed [15:0]  i_angle_z,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    output logic                empty,
    input  logic                pop,
    output logic [5:0]          o_word_index,
    output logic signed [31:0]  o_word_value,
    output logic                o_last_word
);

    // The front holds a finished pose in its output register, which acts as
    // a one-entry queue: it can start on a new pose as soon as the back has
    // taken the previous one, while that packet is still being transferred.
    logic             w_valid;
    logic             w_ready;
    evmp_pkg::t_pose  w_pose;

    evmp_front #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_angle_x (i_angle_x),
        .i_angle_y (i_angle_y),
        .i_angle_z (i_angle_z),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .o_valid   (w_valid),
        .i_ready   (w_ready),
        .o_pose    (w_pose)
    );

    // The back works out the three translation words, then presents one
    // word per transfer in index order.
    evmp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid),
        .o_ready      (w_ready),
        .i_pose       (w_pose),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_word_index (o_word_index),
        .o_word_value (o_word_value),
        .o_last_word  (o_last_word)
    );

endmodule

// ===== verif/tb_euler_view_matrix_packet.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_view_matrix_packet
// Self-checking bench for the Euler angle view matrix packet block. Poses are
// pushed with bursty timing, each is predicted as a 52-word packet, and every
// word popped from the block is checked against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_euler_view_matrix_packet;

    localparam int Steps = 16;

    // One predicted packet word.
    typedef struct {
        logic [5:0]         idx;
        logic signed [31:0] value;
        logic               last;
    } t_word;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic signed [15:0] i_angle_x;
    logic signed [15:0] i_angle_y;
    logic signed [15:0] i_angle_z;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic               empty;
    logic               pop;
    logic [5:0]         o_word_index;
    logic signed [31:0] o_word_value;
    logic               o_last_word;

    t_word packet_words_q[$];
    int    n_errors;
    int    n_poses;
    int    n_words;
    bit    long_stall;
    bit    stall_done;

    euler_view_matrix_packet #(.CORDIC_STEPS(Steps)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_angle_x    (i_angle_x),
        .i_angle_y    (i_angle_y),
        .i_angle_z    (i_angle_z),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .empty        (empty),
        .pop          (pop),
        .o_word_index (o_word_index),
        .o_word_value (o_word_value),
        .o_last_word  (o_last_word)
    );

    always #10 i_clk = ~i_clk;

    // Arithmetic shift right on 64-bit signed values; >>> floors, as required.
    function automatic longint shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint turn_step(input int i);
        longint tbl [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                             21354465, 10679838, 5340245, 2670163, 1335087,
                             667544, 333772, 166886, 83443, 41722, 20861, 10430,
                             5215, 2608, 1304, 652, 326, 163, 81};
        return tbl[i];
    endfunction

    // Rotation-mode CORDIC. Angles beyond a quarter turn are folded by a half
    // turn and the results negated; minus a half turn folds to zero.
    task automatic sin_cos(input logic signed [15:0] ang, output longint s,
                           output longint c);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        a = longint'(ang);
        flip = 0;
        x = longint'(evmp_pkg::CordicGain);
        y = 0;
        if (a > 16384) begin
            a -= 32768;
            flip = 1;
        end else if (a < -16384) begin
            a += 32768;
            flip = 1;
        end
        z = a * 65536;
        for (int i = 0; i < Steps && i < 24; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= turn_step(i);
            end else begin
                x += dx;
                y -= dy;
                z += turn_step(i);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic longint qmul(input longint a, input longint b);
        return shr(a * b, 30);
    endfunction

    // Negated dot product of one matrix row with the position, saturated.
    function automatic logic signed [31:0] translation(input longint e0,
            input longint e1, input longint e2, input longint px,
            input longint py, input longint pz);
        longint sum;
        longint r;
        sum = shr(e0 * px, 14) + shr(e1 * py, 14) + shr(e2 * pz, 14);
        r = shr(-sum, 16);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // Works out the whole packet for one pose and queues its words.
    task automatic predict_packet(input logic signed [15:0] ax,
            input logic signed [15:0] ay, input logic signed [15:0] az,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz);
        longint sx, cx, sy, cy, sz, cz, cc, cs, sc, ss;
        longint lpx, lpy, lpz;
        longint one;
        longint m [11];
        longint w [52];
        t_word  wd;
        lpx = longint'(px);
        lpy = longint'(py);
        lpz = longint'(pz);
        one = longint'(evmp_pkg::FixOne);
        sin_cos(ax, sx, cx);
        sin_cos(ay, sy, cy);
        sin_cos(az, sz, cz);
        cc = qmul(cy, cz);
        cs = qmul(cy, sz);
        sc = qmul(sy, cz);
        ss = qmul(sy, sz);
        m[0] = cc + qmul(ss, sx);
        m[1] = qmul(cx, sz);
        m[2] = qmul(cs, sx) - sc;
        m[3] = 0;
        m[4] = qmul(sc, sx) - cs;
        m[5] = qmul(cx, cz);
        m[6] = qmul(cc, sx) + ss;
        m[7] = 0;
        m[8] = qmul(cx, sy);
        m[9] = -sx;
        m[10] = qmul(cy, cx);
        foreach (w[k]) w[k] = 0;
        for (int k = 0; k < 11; k++) w[k] = shr(m[k], 14);
        w[12] = lpx; w[13] = lpy; w[14] = lpz; w[15] = one;
        w[16] = w[0]; w[17] = w[4]; w[18] = w[8];
        w[20] = w[1]; w[21] = w[5]; w[22] = w[9];
        w[24] = w[2]; w[25] = w[6]; w[26] = w[10];
        w[28] = translation(m[0], m[1], m[2], lpx, lpy, lpz);
        w[29] = translation(m[4], m[5], m[6], lpx, lpy, lpz);
        w[30] = translation(m[8], m[9], m[10], lpx, lpy, lpz);
        w[31] = one;
        w[32] = w[4]; w[33] = w[5]; w[34] = w[6]; w[35] = one;
        w[36] = w[8]; w[37] = w[9]; w[38] = w[10]; w[39] = one;
        w[40] = w[0]; w[41] = w[1]; w[42] = w[2]; w[43] = one;
        w[48] = lpx; w[49] = lpy; w[50] = lpz; w[51] = one;
        for (int k = 0; k < 52; k++) begin
            wd.idx = 6'(k);
            wd.value = w[k][31:0];
            wd.last = (k == 51);
            packet_words_q.push_back(wd);
        end
    endtask

    // Offers one pose until the block takes it. The push stays high across
    // back-to-back transfers; it is only lowered by a gap.
    task automatic send_pose(input logic signed [15:0] ax,
            input logic signed [15:0] ay, input logic signed [15:0] az,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz);
        push <= 1'b1;
        i_angle_x <= ax;
        i_angle_y <= ay;
        i_angle_z <= az;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_packet(ax, ay, az, px, py, pz);
        n_poses++;
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (packet_words_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'(16'sh4000 + $urandom_range(0, 2) - 1);
            2: return 16'(16'shc000 + $urandom_range(0, 2) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    // Extremes of every field, both quarter-turn folds, minus a half turn,
    // and positions large enough to make the translation saturate.
    task automatic test_directed();
        send_pose(0, 0, 0, 0, 0, 0);
        send_pose(16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh7fffffff);
        send_pose(16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000, 32'sh80000000,
                  32'sh80000000);
        send_pose(16384, 16385, -16384, 32'sh00010000, -32'sh00010000, 0);
        send_pose(-16385, 16383, -16383, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_pose(8192, -8192, 24576, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_pose(-24576, 1, -1, -1, 1, -1);
        send_pose(16'sh5555, 16'shaaaa, 16'sh1234, 32'sh55555555, 32'shaaaaaaaa,
                  32'sh12345678);
        send_pose(16'shaaaa, 16'sh5555, 16'shedcb, 32'shaaaaaaaa, 32'sh55555555,
                  32'shedcba987);
        wait_drained();
    endtask

    // Random poses in bursts with random gaps between them.
    task automatic test_random(input int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 6);
            for (int b = 0; b < burst && sent < count; b++) begin
                send_pose(rand_angle(), rand_angle(), rand_angle(), rand_pos(),
                          rand_pos(), rand_pos());
                sent++;
            end
            idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 80));
        end
    endtask

    // The receiver holds off while poses keep coming, so the block fills up
    // and must push back on its input.
    task automatic test_backpressure();
        long_stall = 1;
        for (int k = 0; k < 6; k++)
            send_pose(rand_angle(), rand_angle(), rand_angle(), rand_pos(),
                      rand_pos(), rand_pos());
        push <= 1'b0;
        while (!stall_done) @(posedge i_clk);
        wait_drained();
    endtask

    // Receiver: a random stall pattern drawn anew each cycle, plus one long
    // hold-off counted here when asked for.
    initial begin
        int mode;
        pop <= 1'b0;
        stall_done = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_stall && !stall_done) begin
                pop <= 1'b0;
                repeat (400) @(posedge i_clk);
                stall_done = 1;
            end
            mode = ($urandom_range(0, 255) < 64) ? 0 : 1;
            if (mode == 0) pop <= 1'b1;
            else pop <= ($urandom_range(0, 3) != 0);
        end
    end

    // Checks each transfer at the result side against the oldest prediction.
    always @(posedge i_clk) begin
        t_word wd;
        if (i_rst_n && pop && !empty) begin
            n_words++;
            if (packet_words_q.size() == 0) begin
                n_errors++;
                $display("%0t: word with none predicted: idx %0d value %0d", $time,
                         o_word_index, o_word_value);
            end else begin
                wd = packet_words_q.pop_front();
                if (o_word_index !== wd.idx) begin
                    n_errors++;
                    $display("%0t: index expected %0d actual %0d", $time, wd.idx,
                             o_word_index);
                end
                if (o_word_value !== wd.value) begin
                    n_errors++;
                    $display("%0t: word %0d value expected %0d actual %0d", $time,
                             wd.idx, wd.value, o_word_value);
                end
                if (o_last_word !== wd.last) begin
                    n_errors++;
                    $display("%0t: word %0d last expected %0b actual %0b", $time,
                             wd.idx, wd.last, o_last_word);
                end
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_angle_x <= '0;
        i_angle_y <= '0;
        i_angle_z <= '0;
        i_pos_x <= '0;
        i_pos_y <= '0;
        i_pos_z <= '0;
        n_errors = 0;
        n_poses = 0;
        n_words = 0;
        long_stall = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(50);
        test_backpressure();
        test_random(45);
        wait_drained();
        // Allow a full pose latency for any stray word to surface.
        repeat (100) @(posedge i_clk);
        $display("Covered %0d poses and %0d packet words, including folds, saturation",
                 n_poses, n_words);
        $display("and a long receiver hold-off with the input pushed back.");
        if (n_errors == 0) $display("tb_euler_view_matrix_packet OK");
        else $display("tb_euler_view_matrix_packet NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_euler_view_matrix_packet NOT OK");
        $finish;
    end

endmodule
